/* hdl/dzsf_pkg.sv */
// Shared types, widths and register codes of the dead-zone square-root flow converter.
package dzsf_pkg;

    localparam int ADC_BITS = 12;
    localparam int IN_W     = ADC_BITS + 1;
    localparam int MAG_W    = ADC_BITS + 1;
    localparam int DZ_W     = 12;
    localparam int GAIN_W   = 24;
    localparam int FLOW_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int RAD_W    = MAG_W + FRAC_W;
    localparam int RT_W     = (RAD_W + 1) / 2;
    localparam int RP_W     = 2 * RT_W;
    localparam int REM_W    = RT_W + 2;
    localparam int REMX_W   = REM_W + 2;
    localparam int PROD_W   = RT_W + GAIN_W;
    localparam int RND_W    = PROD_W + 1 - FRAC_W;
    localparam int CMP_W    = (RND_W > FLOW_W) ? RND_W : FLOW_W;
    localparam int CW_W     = (MAG_W > DZ_W) ? MAG_W : DZ_W;
    localparam int QD       = 4;
    localparam int QA_W     = $clog2(QD);
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;

    localparam logic [FLOW_W-1:0] FLOW_MAX = {1'b0, {(FLOW_W-1){1'b1}}};

    // Register index, taken from paddr[2].
    localparam logic REG_DEAD_ZONE = 1'b0;
    localparam logic REG_FLOW_GAIN = 1'b1;

    typedef struct packed {
        logic             neg;
        logic             flag;
        logic [MAG_W-1:0] eff;
    } t_cls;

endpackage

/* hdl/dzsf_if.sv */
// Valid/ready channel interfaces for input samples and flow results.
interface dzsf_in_if;
    import dzsf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  delta_counts;
    modport source (output valid, output delta_counts, input ready);
    modport sink   (input valid, input delta_counts, output ready);
endinterface

interface dzsf_out_if;
    import dzsf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [FLOW_W-1:0] flow_rate;
    logic                     in_dead_zone;
    modport source (output valid, output flow_rate, output in_dead_zone, input ready);
    modport sink   (input valid, input flow_rate, input in_dead_zone, output ready);
endinterface

/* hdl/dzsf_front.sv */
// Front stage: takes the magnitude, applies the dead zone and registers the classified beat.
module dzsf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dzsf_in_if.sink                     i_in,
    input  logic [dzsf_pkg::DZ_W-1:0]   i_dead_zone,
    input  logic                        i_q_full,
    output logic                        o_push,
    output dzsf_pkg::t_cls              o_data
);
    import dzsf_pkg::*;

    logic             r_vld;
    t_cls             r_data;
    t_cls             n_data;
    logic [MAG_W-1:0] w_mag;
    logic [CW_W-1:0]  w_mag_x;
    logic [CW_W-1:0]  w_dz_x;
    logic             w_acc;

    always_comb begin
        n_data.neg  = i_in.delta_counts[IN_W-1];
        w_mag       = n_data.neg ? MAG_W'(-i_in.delta_counts) : MAG_W'(i_in.delta_counts);
        w_mag_x     = CW_W'(w_mag);
        w_dz_x      = CW_W'(i_dead_zone);
        n_data.flag = (w_mag_x < w_dz_x);
        n_data.eff  = n_data.flag ? '0 : MAG_W'(w_mag_x - w_dz_x);
    end

    assign i_in.ready = !r_vld || !i_q_full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign o_push     = r_vld && !i_q_full;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_data <= n_data;
        end
    end

endmodule

/* hdl/dzsf_queue.sv */
// Small FIFO of classified beats between the front and back stages.
module dzsf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dzsf_pkg::t_cls i_data,
    input  logic           i_pop,
    output dzsf_pkg::t_cls o_data,
    output logic           o_full,
    output logic           o_empty
);
    import dzsf_pkg::*;

    t_cls            r_mem [QD];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QA_W+1)'(QD));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* hdl/dzsf_back.sv */
// Back stages: pipelined digit-by-digit square root, gain multiply, rounding and sign.
module dzsf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dzsf_pkg::t_cls               i_q_data,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  logic [dzsf_pkg::GAIN_W-1:0]  i_flow_gain,
    dzsf_out_if.source                   o_out
);
    import dzsf_pkg::*;

    // Root stage k holds the partial result after k+1 root digits.
    logic              r_s_vld  [RT_W];
    logic              r_s_neg  [RT_W];
    logic              r_s_flag [RT_W];
    logic [RP_W-1:0]   r_s_rad  [RT_W];
    logic [REM_W-1:0]  r_s_rem  [RT_W];
    logic [RT_W-1:0]   r_s_root [RT_W];

    logic [RP_W-1:0]   w_in_rad  [RT_W];
    logic [REM_W-1:0]  w_in_rem  [RT_W];
    logic [RT_W-1:0]   w_in_root [RT_W];
    logic [RP_W-1:0]   w_nx_rad  [RT_W];
    logic [REM_W-1:0]  w_nx_rem  [RT_W];
    logic [RT_W-1:0]   w_nx_root [RT_W];
    logic [REMX_W-1:0] w_rem_s   [RT_W];
    logic [REMX_W-1:0] w_trial   [RT_W];

    logic               r_m_vld;
    logic               r_m_neg;
    logic               r_m_flag;
    logic [PROD_W-1:0]  r_m_prod;

    logic               r_o_vld;
    logic [FLOW_W-1:0]  r_o_flow;
    logic               r_o_flag;

    logic               w_adv;
    logic [PROD_W:0]    w_sum;
    logic [CMP_W-1:0]   w_rnd;
    logic [FLOW_W-1:0]  w_sat;
    logic [FLOW_W-1:0]  n_o_flow;

    // The whole back end moves as one when the output register can take a beat.
    assign w_adv   = !r_o_vld || o_out.ready;
    assign o_q_pop = w_adv && !i_q_empty;

    always_comb begin
        for (int k = 0; k < RT_W; k++) begin
            if (k == 0) begin
                w_in_rad[k]  = RP_W'({i_q_data.eff, {FRAC_W{1'b0}}});
                w_in_rem[k]  = '0;
                w_in_root[k] = '0;
            end else begin
                w_in_rad[k]  = r_s_rad[k-1];
                w_in_rem[k]  = r_s_rem[k-1];
                w_in_root[k] = r_s_root[k-1];
            end
            w_rem_s[k]  = {w_in_rem[k], w_in_rad[k][RP_W-1 -: 2]};
            w_trial[k]  = REMX_W'({w_in_root[k], 2'b01});
            w_nx_rad[k] = w_in_rad[k] << 2;
            if (w_rem_s[k] >= w_trial[k]) begin
                w_nx_rem[k]  = REM_W'(w_rem_s[k] - w_trial[k]);
                w_nx_root[k] = {w_in_root[k][RT_W-2:0], 1'b1};
            end else begin
                w_nx_rem[k]  = REM_W'(w_rem_s[k]);
                w_nx_root[k] = {w_in_root[k][RT_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        w_sum = (PROD_W+1)'(r_m_prod) + (PROD_W+1)'(1 << (FRAC_W - 1));
        w_rnd = CMP_W'(w_sum[PROD_W:FRAC_W]);
        w_sat = (w_rnd > CMP_W'(FLOW_MAX)) ? FLOW_MAX : w_rnd[FLOW_W-1:0];
        if (r_m_flag) begin
            n_o_flow = '0;
        end else if (r_m_neg) begin
            n_o_flow = -w_sat;
        end else begin
            n_o_flow = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RT_W; k++) begin
                r_s_vld[k] <= 1'b0;
            end
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_s_vld[0] <= !i_q_empty;
            for (int k = 1; k < RT_W; k++) begin
                r_s_vld[k] <= r_s_vld[k-1];
            end
            r_m_vld <= r_s_vld[RT_W-1];
            r_o_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_neg[0]  <= i_q_data.neg;
            r_s_flag[0] <= i_q_data.flag;
            for (int k = 1; k < RT_W; k++) begin
                r_s_neg[k]  <= r_s_neg[k-1];
                r_s_flag[k] <= r_s_flag[k-1];
            end
            for (int k = 0; k < RT_W; k++) begin
                r_s_rad[k]  <= w_nx_rad[k];
                r_s_rem[k]  <= w_nx_rem[k];
                r_s_root[k] <= w_nx_root[k];
            end
            r_m_neg  <= r_s_neg[RT_W-1];
            r_m_flag <= r_s_flag[RT_W-1];
            r_m_prod <= PROD_W'(r_s_root[RT_W-1]) * PROD_W'(i_flow_gain);
            r_o_flow <= n_o_flow;
            r_o_flag <= r_m_flag;
        end
    end

    assign o_out.valid        = r_o_vld;
    assign o_out.flow_rate    = r_o_flow;
    assign o_out.in_dead_zone = r_o_flag;

endmodule

/* hdl/dead_zone_sqrt_flow_conversion.sv */
// Top level of the dead-zone square-root flow converter with its register port.
//
//  Channel   Dir  Handshake        Beat contents
//  i_in      in   valid / ready    delta_counts (13-bit signed ADC difference)
//  o_out     out  valid / ready    flow_rate (24-bit signed, 1/256 L/min), in_dead_zone
//  APB       in   psel / penable   dead_zone at 0x0, flow_gain at 0x4
//
// One beat is accepted per clock when nothing stalls. A beat passes through the front
// register, the queue, the RT_W square-root stages (one root digit per stage, 15 at
// 12 ADC bits), the multiplier register and the output register. Reset is synchronous
// and clears all valid flags and queue pointers; both registers reset to zero.
// A stall at the output freezes the back stages only; the front keeps accepting until
// the queue fills.
module dead_zone_sqrt_flow_conversion (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dzsf_in_if.sink                          i_in,
    dzsf_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dzsf_pkg::PADDR_W-1:0]     paddr,
    input  logic [dzsf_pkg::APB_W-1:0]       pwdata,
    output logic [dzsf_pkg::APB_W-1:0]       prdata,
    output logic                             pready
);
    import dzsf_pkg::*;

    logic [DZ_W-1:0]   r_dead_zone;
    logic [GAIN_W-1:0] r_flow_gain;
    logic              w_wr;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    t_cls              w_f_data;
    t_cls              w_q_data;

    // Configuration registers. The register index is address bit 2; the lower bits are
    // ignored. The user must write only while the datapath is idle; it is not enforced.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= '0;
            r_flow_gain <= '0;
        end else if (w_wr) begin
            if (paddr[2] == REG_DEAD_ZONE) begin
                r_dead_zone <= pwdata[DZ_W-1:0];
            end else begin
                r_flow_gain <= pwdata[GAIN_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FLOW_GAIN) begin
            prdata = APB_W'(r_flow_gain);
        end else begin
            prdata = APB_W'(r_dead_zone);
        end
    end

    // The front takes the magnitude and subtracts the dead zone, so the back end
    // only ever sees a non-negative remainder plus the sign and dead-zone flag.
    dzsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_dead_zone (r_dead_zone),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_data      (w_f_data)
    );

    // The queue decouples the two halves so that an output stall does not
    // immediately block the input.
    dzsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_f_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // The back end computes floor(sqrt(remainder * 2^16)), multiplies by the
    // Q8.16 gain, rounds half up to Q.8, saturates and restores the sign.
    dzsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (w_q_data),
        .i_q_empty   (w_empty),
        .o_q_pop     (w_pop),
        .i_flow_gain (r_flow_gain),
        .o_out       (o_out)
    );

endmodule

/* hdl/dzsf_checker.sv */
// Port-level checker for the flow converter and its bind to the top level.
module dzsf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [dzsf_pkg::FLOW_W-1:0]      i_flow_rate,
    input logic                             i_in_dead_zone,
    input logic                             i_psel,
    input logic                             i_penable,
    input logic                             i_pwrite,
    input logic [dzsf_pkg::PADDR_W-1:0]     i_paddr,
    input logic [dzsf_pkg::APB_W-1:0]       i_pwdata,
    input logic [dzsf_pkg::APB_W-1:0]       i_prdata
);
    import dzsf_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A beat in the dead zone always carries zero flow.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_in_dead_zone) |-> (i_flow_rate == '0))
        else $error("dead-zone beat with nonzero flow");

    // Saturation is symmetric, so the most negative code never appears.
    a_sat_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_flow_rate != {1'b1, {(FLOW_W-1){1'b0}}}))
        else $error("flow below negative saturation limit");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_flow_rate) && $stable(i_in_dead_zone)))
        else $error("output beat changed while stalled");

    // A dead-zone write reads back on the next cycle.
    a_dz_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_DEAD_ZONE))
            ##1 (i_psel && !i_pwrite && (i_paddr[2] == REG_DEAD_ZONE)))
        |-> (i_prdata == {{(APB_W-DZ_W){1'b0}}, $past(i_pwdata[DZ_W-1:0])}))
        else $error("dead_zone readback mismatch");

endmodule

bind dead_zone_sqrt_flow_conversion dzsf_checker u_dzsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_flow_rate    (o_out.flow_rate),
    .i_in_dead_zone (o_out.in_dead_zone),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata)
);

/* tb/testbench.sv */
// Self-checking testbench for the dead-zone square-root flow converter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dzsf_pkg::*;

    // Each side holds off about this percent of the time.
    localparam int IDLE_PCT      = 35;
    // Random traffic is split into phases, each with its own register setting.
    localparam int N_PHASES      = 8;
    localparam int BEATS_PER_PH  = 125;
    // The phase that runs with no idling on either side.
    localparam int STEADY_PHASE  = 2;
    // Wait after the pipeline drains; this margin catches stray beats.
    localparam int TAIL_CYCLES   = 40;
    // Cycles without any accepted beat or register access before giving up.
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int MAG_TOP       = (1 << ADC_BITS) - 1;

    // One expected output beat.
    typedef struct packed {
        logic signed [FLOW_W-1:0] flow;
        logic                     flag;
    } flow_beat_t;

    // One directed sample with the register setting it needs. Where typed is
    // set, the expected flow and flag follow directly; otherwise the
    // predictor supplies them.
    typedef struct packed {
        logic [DZ_W-1:0]          dz;
        logic [GAIN_W-1:0]        gain;
        logic signed [IN_W-1:0]   delta;
        logic                     typed;
        logic signed [FLOW_W-1:0] flow;
        logic                     flag;
    } sample_row_t;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);

    // The directed part. The first group runs on the reset values, so no
    // register is written before it. With 12 ADC bits the root reaches at
    // most 2^14 and the flow at most 2^22, so output saturation cannot be
    // reached.
    sample_row_t dir_rows [24] = '{
        // Reset setting: zero gain gives zero flow everywhere, no flag.
        '{12'd0,    24'd0,    0,     1'b1, 0,     1'b0},
        '{12'd0,    24'd0,    4095,  1'b1, 0,     1'b0},
        '{12'd0,    24'd0,    -4096, 1'b1, 0,     1'b0},
        '{12'd0,    24'd0,    -1,    1'b1, 0,     1'b0},
        // Largest gain, no dead zone: the biggest products.
        '{12'd0,    GAIN_MAX, 4095,  1'b0, 0,     1'b0},
        '{12'd0,    GAIN_MAX, -4096, 1'b0, 0,     1'b0},
        '{12'd0,    GAIN_MAX, 0,     1'b1, 0,     1'b0},
        '{12'd0,    GAIN_MAX, 1,     1'b0, 0,     1'b0},
        '{12'd0,    GAIN_MAX, -1,    1'b0, 0,     1'b0},
        '{12'd0,    GAIN_MAX, 2730,  1'b0, 0,     1'b0},
        '{12'd0,    GAIN_MAX, -2731, 1'b0, 0,     1'b0},
        // Widest dead zone with unit gain. The most negative input still
        // clears it by one count, which is a root of exactly 1.0.
        '{12'd4095, GAIN_ONE, 4094,  1'b1, 0,     1'b1},
        '{12'd4095, GAIN_ONE, -4094, 1'b1, 0,     1'b1},
        '{12'd4095, GAIN_ONE, 0,     1'b1, 0,     1'b1},
        '{12'd4095, GAIN_ONE, 4095,  1'b1, 0,     1'b0},
        '{12'd4095, GAIN_ONE, -4096, 1'b1, -256,  1'b0},
        // A middle dead zone probed on both sides of its edge.
        '{12'd100,  24'h123456, 100,   1'b1, 0,   1'b0},
        '{12'd100,  24'h123456, 99,    1'b1, 0,   1'b1},
        '{12'd100,  24'h123456, -99,   1'b1, 0,   1'b1},
        '{12'd100,  24'h123456, -100,  1'b1, 0,   1'b0},
        '{12'd100,  24'h123456, 101,   1'b0, 0,   1'b0},
        '{12'd100,  24'h123456, -101,  1'b0, 0,   1'b0},
        '{12'd100,  24'h123456, 2000,  1'b0, 0,   1'b0},
        '{12'd100,  24'h123456, -3000, 1'b0, 0,   1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    dzsf_in_if  in_ch ();
    dzsf_out_if out_ch ();

    dead_zone_sqrt_flow_conversion u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The register setting the block holds right now, mirrored here.
    logic [DZ_W-1:0]   cur_dz;
    logic [GAIN_W-1:0] cur_gain;
    // Expected output beats, oldest first.
    flow_beat_t        pending_flows [$];
    int                fail_count;
    int                quiet_cycles;
    // While set, neither side idles.
    bit                steady;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_failure(input string what, input longint want, input longint got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        end
    endtask

    // Flow for one sample under the current setting. The root is built one
    // bit at a time from the top, keeping each bit whose square still fits.
    function automatic flow_beat_t predict_flow(input logic signed [IN_W-1:0] delta);
        flow_beat_t      beat;
        logic            neg;
        logic [MAG_W-1:0] mag;
        logic [63:0]     radicand;
        logic [63:0]     root;
        logic [63:0]     trial;
        logic [63:0]     scaled;
        beat.flow = '0;
        beat.flag = 1'b0;
        neg = delta[IN_W-1];
        mag = neg ? MAG_W'(-delta) : MAG_W'(delta);
        if (mag < cur_dz) begin
            beat.flag = 1'b1;
        end else begin
            radicand = 64'(mag - cur_dz) << FRAC_W;
            root = '0;
            for (int b = RT_W - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= radicand) begin
                    root = trial;
                end
            end
            // Q.8 root times Q8.16 gain, rounded half up back to Q.8.
            scaled = (root * cur_gain + 64'h8000) >> FRAC_W;
            if (scaled > FLOW_MAX) begin
                scaled = FLOW_MAX;
            end
            beat.flow = neg ? -scaled[FLOW_W-1:0] : scaled[FLOW_W-1:0];
        end
        return beat;
    endfunction

    // Random sample: half the time anywhere in the 13-bit range, otherwise equally often
    // right at the dead-zone edge or at one of the range corners.
    function automatic logic signed [IN_W-1:0] random_delta();
        int m;
        int corners [5] = '{MAG_TOP, -(MAG_TOP + 1), 0, 1, -1};
        case ($urandom_range(3))
            0, 1: begin
                return IN_W'($urandom_range(0, (1 << IN_W) - 1));
            end
            2: begin
                m = int'(cur_dz) + int'($urandom_range(0, 4)) - 2;
                if (m < 0) begin
                    m = 0;
                end
                if (m > MAG_TOP) begin
                    m = MAG_TOP;
                end
                return $urandom_range(1) ? IN_W'(-m) : IN_W'(m);
            end
            default: begin
                return IN_W'(corners[$urandom_range(4)]);
            end
        endcase
    endfunction

    // Write one register, then read it back. Entered just after a falling
    // edge and left just after one, with psel still high so that a second
    // transfer can follow at once.
    task automatic program_reg(input logic sel_idx, input logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== value) begin
            note_failure("register read-back", value, prdata);
        end
        @(negedge i_clk);
    endtask

    // Registers may only change while the pipeline is empty, so stop
    // sending and let every outstanding beat come out first.
    task automatic apply_setting(input logic [DZ_W-1:0] dz, input logic [GAIN_W-1:0] gain);
        in_ch.valid <= 1'b0;
        while (pending_flows.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        program_reg(REG_DEAD_ZONE, APB_W'(dz));
        program_reg(REG_FLOW_GAIN, APB_W'(gain));
        psel     <= 1'b0;
        penable  <= 1'b0;
        cur_dz   = dz;
        cur_gain = gain;
    endtask

    // Offer one input beat, with random hold-off ahead of it. The valid is
    // left high afterwards so back-to-back beats never drop it.
    task automatic send_sample(input logic signed [IN_W-1:0] delta, input flow_beat_t want);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_ch.valid        <= 1'b1;
        in_ch.delta_counts <= delta;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_flows.push_back(want);
        @(negedge i_clk);
    endtask

    // The output side stalls at random, except in the steady phase.
    always @(negedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Every accepted output beat is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_out
        flow_beat_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_flows.size() == 0) begin
                note_failure("unexpected beat, flow_rate", 0, out_ch.flow_rate);
            end else begin
                want = pending_flows.pop_front();
                if (out_ch.flow_rate !== want.flow) begin
                    note_failure("flow_rate", want.flow, out_ch.flow_rate);
                end
                if (out_ch.in_dead_zone !== want.flag) begin
                    note_failure("in_dead_zone", want.flag, out_ch.in_dead_zone);
                end
            end
        end
    end

    // A hung handshake ends the run instead of letting it spin forever.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        flow_beat_t        want;
        logic [DZ_W-1:0]   dz;
        logic [GAIN_W-1:0] gain;
        fail_count         = 0;
        quiet_cycles       = 0;
        steady             = 1'b0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.delta_counts = '0;
        out_ch.ready       = 1'b0;
        cur_dz             = '0;
        cur_gain           = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed samples. A row whose setting differs from the one in
        // force first drains the pipeline and reprograms both registers.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].dz != cur_dz || dir_rows[i].gain != cur_gain) begin
                apply_setting(dir_rows[i].dz, dir_rows[i].gain);
            end
            if (dir_rows[i].typed) begin
                want.flow = dir_rows[i].flow;
                want.flag = dir_rows[i].flag;
            end else begin
                want = predict_flow(dir_rows[i].delta);
            end
            send_sample(dir_rows[i].delta, want);
        end

        // Random phases. The first keeps the largest gain with no dead zone,
        // the second the widest dead zone, the last a zero gain; the rest
        // draw both registers at random, most often with a modest dead zone
        // so that the square-root path carries most of the traffic.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            dz   = $urandom_range(1) ? DZ_W'($urandom_range(0, 255))
                                     : DZ_W'($urandom_range(0, MAG_TOP));
            gain = GAIN_W'($urandom_range(0, GAIN_MAX));
            if (ph == 0) begin
                dz   = '0;
                gain = GAIN_MAX;
            end else if (ph == 1) begin
                dz = DZ_W'(MAG_TOP);
            end else if (ph == N_PHASES - 1) begin
                gain = '0;
            end
            apply_setting(dz, gain);
            steady = (ph == STEADY_PHASE);
            repeat (BEATS_PER_PH) begin
                logic signed [IN_W-1:0] delta;
                delta = random_delta();
                send_sample(delta, predict_flow(delta));
            end
        end
        steady = 1'b0;
        in_ch.valid <= 1'b0;

        // Let everything drain, then watch a little longer for stray beats.
        while (pending_flows.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_flows.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
